/* rtl/core/bcrtc_pkg.sv */
package bcrtc_pkg;

    // item kinds
    localparam logic [1:0] KIND_CTRL   = 2'd0;
    localparam logic [1:0] KIND_RAM_WR = 2'd1;
    localparam logic [1:0] KIND_RAM_RD = 2'd2;
    localparam logic [1:0] KIND_TICK   = 2'd3;

    // control write regions, address bits 14..13
    localparam logic [1:0] REG_RAM_EN   = 2'd0;
    localparam logic [1:0] REG_ROM_BANK = 2'd1;
    localparam logic [1:0] REG_RAM_BANK = 2'd2;
    localparam logic [1:0] REG_LATCH    = 2'd3;

    // clock register numbers
    localparam logic [7:0] RTC_SEC  = 8'h08;
    localparam logic [7:0] RTC_MIN  = 8'h09;
    localparam logic [7:0] RTC_HOUR = 8'h0A;
    localparam logic [7:0] RTC_DAY  = 8'h0B;
    localparam logic [7:0] RTC_CTRL = 8'h0C;

    // configuration register indexes
    localparam logic [1:0] CFG_ROM_MASK    = 2'd0;
    localparam logic [1:0] CFG_RAM_MASK    = 2'd1;
    localparam logic [1:0] CFG_RAM_PRESENT = 2'd2;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 15;

    localparam logic [7:0] BYTE_NONE   = 8'hFF;
    localparam logic [7:0] RAM_EN_KEY  = 8'h0A;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [7:0]  data;
    } t_item;

    // one-cycle commands from the mapper to the clock registers
    typedef struct packed {
        logic       tick;
        logic       wr_en;
        logic       latch;
        logic [7:0] sel;
        logic [7:0] wdata;
    } t_rtc_ctrl;

    typedef struct packed {
        logic [6:0]  rom_bank;
        logic [14:0] ram_address;
        logic        ram_write;
        logic        ram_read;
        logic [7:0]  ram_write_data;
        logic [7:0]  read_data;
    } t_result;

endpackage

/* rtl/core/bcrtc_rtc.sv */
module bcrtc_rtc
    import bcrtc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_rtc_ctrl i_ctrl,
    output logic [7:0] o_rdata
);

    logic [7:0] r_live_sec, r_live_min, r_live_hour, r_live_ctrl;
    logic [8:0] r_live_day;
    logic [7:0] r_held_sec, r_held_min, r_held_hour, r_held_day, r_held_ctrl;

    logic [7:0] n_live_sec, n_live_min, n_live_hour, n_live_ctrl;
    logic [8:0] n_live_day;

    logic [8:0] s_sec, s_min, s_hour;
    logic [9:0] s_day;
    logic [7:0] s_ctrl;

    // one second with carries
    always_comb begin
        s_sec  = {1'b0, r_live_sec} + 9'd1;
        s_min  = {1'b0, r_live_min};
        s_hour = {1'b0, r_live_hour};
        s_day  = {1'b0, r_live_day};
        s_ctrl = r_live_ctrl;
        if (s_sec > 9'd59) begin
            s_sec = s_sec - 9'd60;
            s_min = s_min + 9'd1;
        end
        if (s_min > 9'd59) begin
            s_min  = s_min - 9'd60;
            s_hour = s_hour + 9'd1;
        end
        if (s_hour > 9'd23) begin
            s_hour = s_hour - 9'd24;
            s_day  = s_day + 10'd1;
        end
        if (s_day > 10'd255) begin
            if (s_day > 10'd511) begin
                s_day     = {1'b0, s_day[8:0]};
                s_ctrl[7] = 1'b1;
            end
            s_ctrl[0] = (s_day > 10'd255);
        end
    end

    always_comb begin
        n_live_sec  = r_live_sec;
        n_live_min  = r_live_min;
        n_live_hour = r_live_hour;
        n_live_day  = r_live_day;
        n_live_ctrl = r_live_ctrl;
        if (i_ctrl.tick) begin
            n_live_sec  = s_sec[7:0];
            n_live_min  = s_min[7:0];
            n_live_hour = s_hour[7:0];
            n_live_day  = s_day[8:0];
            n_live_ctrl = s_ctrl;
        end else if (i_ctrl.wr_en) begin
            case (i_ctrl.sel)
                RTC_SEC:  n_live_sec  = i_ctrl.wdata;
                RTC_MIN:  n_live_min  = i_ctrl.wdata;
                RTC_HOUR: n_live_hour = i_ctrl.wdata;
                RTC_DAY:  n_live_day  = {1'b0, i_ctrl.wdata};
                RTC_CTRL: n_live_ctrl = {r_live_ctrl[7], 7'd0} | i_ctrl.wdata;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live_sec  <= '0;
            r_live_min  <= '0;
            r_live_hour <= '0;
            r_live_day  <= '0;
            r_live_ctrl <= '0;
            r_held_sec  <= '0;
            r_held_min  <= '0;
            r_held_hour <= '0;
            r_held_day  <= '0;
            r_held_ctrl <= '0;
        end else begin
            r_live_sec  <= n_live_sec;
            r_live_min  <= n_live_min;
            r_live_hour <= n_live_hour;
            r_live_day  <= n_live_day;
            r_live_ctrl <= n_live_ctrl;
            if (i_ctrl.latch) begin
                r_held_sec  <= r_live_sec;
                r_held_min  <= r_live_min;
                r_held_hour <= r_live_hour;
                r_held_day  <= r_live_day[7:0];
                r_held_ctrl <= r_live_ctrl;
            end
        end
    end

    always_comb begin
        case (i_ctrl.sel)
            RTC_SEC:  o_rdata = r_held_sec;
            RTC_MIN:  o_rdata = r_held_min;
            RTC_HOUR: o_rdata = r_held_hour;
            RTC_DAY:  o_rdata = r_held_day;
            RTC_CTRL: o_rdata = r_held_ctrl;
            default:  o_rdata = BYTE_NONE;
        endcase
    end

endmodule

/* rtl/core/bcrtc_map.sv */
module bcrtc_map
    import bcrtc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_step,
    input  t_item                i_item,
    input  logic [7:0]           i_rtc_rdata,
    output t_rtc_ctrl            o_rtc_ctrl,
    output t_result              o_result
);

    logic [6:0]  r_rom_mask;
    logic [14:0] r_ram_mask;
    logic        r_ram_present;

    logic        r_ram_en, n_ram_en;
    logic [6:0]  r_rom_bank, n_rom_bank;
    logic [14:0] r_ram_offset, n_ram_offset;
    logic        r_clock_mode, n_clock_mode;
    logic [7:0]  r_clock_sel, n_clock_sel;
    logic        r_latch_armed, n_latch_armed;

    logic [14:0] s_ram_addr;
    logic        s_clock_acc;

    assign s_ram_addr  = r_ram_offset + {2'b00, i_item.address[12:0]};
    assign s_clock_acc = r_ram_en && r_clock_mode;

    always_comb begin
        n_ram_en      = r_ram_en;
        n_rom_bank    = r_rom_bank;
        n_ram_offset  = r_ram_offset;
        n_clock_mode  = r_clock_mode;
        n_clock_sel   = r_clock_sel;
        n_latch_armed = r_latch_armed;

        o_rtc_ctrl       = '0;
        o_rtc_ctrl.sel   = r_clock_sel;
        o_rtc_ctrl.wdata = i_item.data;

        o_result                = '0;
        o_result.read_data      = BYTE_NONE;

        case (i_item.kind)
            KIND_CTRL: begin
                case (i_item.address[14:13])
                    REG_RAM_EN: begin
                        n_ram_en = ((i_item.data & RAM_EN_KEY) == RAM_EN_KEY);
                    end
                    REG_ROM_BANK: begin
                        n_rom_bank = (i_item.data[6:0] == 7'd0) ? 7'd1 : i_item.data[6:0];
                    end
                    REG_RAM_BANK: begin
                        if (i_item.data < 8'd8) begin
                            n_clock_mode = 1'b0;
                            n_ram_offset = {i_item.data[1:0], 13'd0} & r_ram_mask;
                        end else if (r_ram_en) begin
                            n_clock_mode = 1'b1;
                            n_clock_sel  = i_item.data;
                        end
                    end
                    default: begin
                        // latch on a zero then one sequence
                        o_rtc_ctrl.latch = i_step && !r_latch_armed && (i_item.data == 8'd1);
                        if (i_item.data <= 8'd1) begin
                            n_latch_armed = i_item.data[0];
                        end
                    end
                endcase
            end
            KIND_RAM_WR: begin
                if (r_ram_en) begin
                    if (!r_clock_mode) begin
                        if (r_ram_present) begin
                            o_result.ram_address    = s_ram_addr;
                            o_result.ram_write      = 1'b1;
                            o_result.ram_write_data = i_item.data;
                        end
                    end else begin
                        o_rtc_ctrl.wr_en = i_step;
                    end
                end
            end
            KIND_RAM_RD: begin
                if (r_ram_en && !r_clock_mode) begin
                    o_result.ram_address = s_ram_addr;
                    o_result.ram_read    = 1'b1;
                end else if (s_clock_acc) begin
                    o_result.read_data = i_rtc_rdata;
                end
            end
            default: begin
                o_rtc_ctrl.tick = i_step;
            end
        endcase

        // rom bank reported after this item's update
        o_result.rom_bank = n_rom_bank & r_rom_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_mask    <= 7'h7F;
            r_ram_mask    <= 15'h7FFF;
            r_ram_present <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROM_MASK:    r_rom_mask    <= i_cfg_data[6:0];
                CFG_RAM_MASK:    r_ram_mask    <= i_cfg_data[14:0];
                CFG_RAM_PRESENT: r_ram_present <= i_cfg_data[0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_en      <= 1'b0;
            r_rom_bank    <= 7'd1;
            r_ram_offset  <= '0;
            r_clock_mode  <= 1'b0;
            r_clock_sel   <= '0;
            r_latch_armed <= 1'b0;
        end else if (i_step) begin
            r_ram_en      <= n_ram_en;
            r_rom_bank    <= n_rom_bank;
            r_ram_offset  <= n_ram_offset;
            r_clock_mode  <= n_clock_mode;
            r_clock_sel   <= n_clock_sel;
            r_latch_armed <= n_latch_armed;
        end
    end

endmodule

/* rtl/core/bank_controller_with_rtc.sv */
// Cartridge bank controller with real-time clock. Each input item is a control write,
// an external RAM write, an external RAM read or a one-second tick; each gives exactly one
// result item with the masked ROM bank, the RAM address and strobes, the byte to write and
// the latched clock value (0xFF when RAM is disabled or the register is unknown). Items are
// taken one per clock while the result side keeps taking: an item is held in the input
// register, is decoded against the bank and clock state in a single pass, and its result
// lands in the output register. A stalled result holds one further item in the input
// register. Configuration writes take effect on the next clock and are meant for idle periods.
module bank_controller_with_rtc
    import bcrtc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // input items
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,   // address[15:0], data[23:16]
    input  logic [1:0]           s_axis_tuser,   // kind[1:0]
    // result items
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // rom_bank[6:0], ram_address[21:7], ram_write[22], ram_read[23],
    // ram_write_data[31:24], read_data[39:32]
    output logic [39:0]          m_axis_tdata
);

    t_item     r_in;
    logic      r_in_valid;
    t_result   r_out;
    logic      r_out_valid;

    logic      s_advance;
    logic      s_accept;
    t_result   s_result;
    t_rtc_ctrl s_rtc_ctrl;
    logic [7:0] s_rtc_rdata;

    // input register moves on whenever the output register is free or being emptied
    assign s_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || s_advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (s_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in.kind    <= s_axis_tuser;
            r_in.address <= s_axis_tdata[15:0];
            r_in.data    <= s_axis_tdata[23:16];
        end
    end

    // bank registers, config and the result decode
    bcrtc_map u_map (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (s_advance),
        .i_item      (r_in),
        .i_rtc_rdata (s_rtc_rdata),
        .o_rtc_ctrl  (s_rtc_ctrl),
        .o_result    (s_result)
    );

    // live and latched clock registers
    bcrtc_rtc u_rtc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (s_rtc_ctrl),
        .o_rdata (s_rtc_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_advance) begin
            r_out <= s_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.read_data, r_out.ram_write_data, r_out.ram_read,
                            r_out.ram_write, r_out.ram_address, r_out.rom_bank};

    // a result waiting on a stalled sink is never dropped
    a_out_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |=> r_out_valid)
        else $error("result item lost while stalled");

    // a full input register only takes a new item when its own item moves on
    a_in_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && r_in_valid |-> s_advance)
        else $error("input register overwritten");

    // ram strobes exclude each other and a strobed read leaves read_data at 0xFF
    a_strobe_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.ram_read |->
            !r_out.ram_write && r_out.ram_write_data == 8'd0 && r_out.read_data == BYTE_NONE)
        else $error("inconsistent ram read result");

endmodule
